/* src/apngfc_pkg.sv */
// shared types and constants of the apng frame compositor
package apngfc_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int DIM_W          = 9;
	localparam int COORD_W        = 8;
	localparam int PIX_W          = 32;
	localparam int POS_W          = 18;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 4;
	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 4'd1;

	localparam logic [1:0] DISP_NONE    = 2'd0;
	localparam logic [1:0] DISP_CLEAR   = 2'd1;
	localparam logic [1:0] DISP_RESTORE = 2'd2;

	localparam logic BLEND_SOURCE = 1'b0;
	localparam logic BLEND_OVER   = 1'b1;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_READ  = 2'd2,
		ACT_UNDEF = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_REGION = 2'd1,
		STAT_SEQ    = 2'd2
	} status_t;

	typedef struct packed {
		action_t              action;
		logic [DIM_W-1:0]     rw;
		logic [DIM_W-1:0]     rh;
		logic [COORD_W-1:0]   rx;
		logic [COORD_W-1:0]   ry;
		logic [1:0]           dispose;
		logic                 blend;
		logic [PIX_W-1:0]     pixel;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [DIM_W-1:0] cw;
		logic [DIM_W-1:0] ch;
		logic             changed;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_WALK,
		BK_WALK_END,
		BK_PIX_WR,
		BK_RD_DIV,
		BK_RD_ISSUE,
		BK_RD_OUT
	} bk_state_t;

endpackage

/* src/apngfc_ram.sv */
// generic simple dual port ram with registered read
module apngfc_ram #(
	parameter int W = 32,
	parameter int D = 1024,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/apngfc_front.sv */
// front end: accepts beats, classifies the action and queues the items
module apngfc_front import apngfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  item_t   item_in,
	input  logic    pop,
	output q_head_t head
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	item_t         mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;
	logic          push;
	item_t         item_cls;

	// undefined action codes all map onto one class
	always_comb begin
		item_cls = item_in;
		unique case (item_in.action)
			ACT_BEGIN: item_cls.action = ACT_BEGIN;
			ACT_PIXEL: item_cls.action = ACT_PIXEL;
			ACT_READ:  item_cls.action = ACT_READ;
			default:   item_cls.action = ACT_UNDEF;
		endcase
	end

	assign in_stall   = (count_q == (QW+1)'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QW+1)'(1);
				2'b01:   count_q <= count_q - (QW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QW+1)'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + (QW+1)'(1)))
		else $error("queue count not tracking push");

endmodule

/* src/apngfc_back.sv */
// back end: canvas memories, disposal walk, blending and canvas read-out
module apngfc_back import apngfc_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  q_head_t          head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [PIX_W-1:0] pixel_out,
	output logic             last
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bk_state_t          state_q, state_d;
	logic [AW-1:0]      clr_addr_q;
	item_t              item_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [PIX_W-1:0]   pixel_q;
	logic               last_q;
	logic [COORD_W-1:0] cur_rx_q, cur_ry_q;
	logic [DIM_W-1:0]   cur_rw_q, cur_rh_q;
	logic [1:0]         cur_disp_q;
	logic               cur_blend_q;
	logic               first_q;
	logic [DIM_W-1:0]   col_q, row_q;
	logic [POS_W-1:0]   rd_pos_q;
	logic [DIM_W-1:0]   rd_col_q, rd_row_q;
	logic               remap_q;
	logic               bad_q;
	logic               open_q;
	logic [DIM_W-1:0]   wi_q, wj_q;
	logic               wr_vld_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic               wr_clr_s1;
	logic [AW-1:0]      pix_addr_s1;
	logic               pix_in_s1;
	logic [4:0]         div_cnt_q;
	logic [DIM_W:0]     div_rem_q;
	logic [POS_W-1:0]   div_quo_q;

	logic             c_we, s_we;
	logic [AW-1:0]    c_waddr, s_waddr, c_raddr, s_raddr;
	logic [PIX_W-1:0] c_wdata, s_wdata, c_rdata, s_rdata;

	logic [POS_W-1:0] total;
	logic [DIM_W:0]   cx, cy;
	logic [AW-1:0]    pix_addr, walk_addr, rd_addr;
	logic             pix_in, walk_clr, walk_done;
	item_t            begin_src;
	logic             do_begin, begin_bad;
	logic [DIM_W:0]   rem_sh, rem_nx;
	logic             quo_bit;
	logic [POS_W-1:0] quo_nx, pos_eff;

	function automatic logic [AW-1:0] addr_of(input logic [DIM_W:0] x, input logic [DIM_W:0] y);
		return AW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	function automatic logic [7:0] mix_ch(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		logic signed [8:0]  diff;
		logic signed [17:0] p;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		p    = $signed({1'b0, a}) * diff;
		return d + p[15:8];
	endfunction

	function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] src,
		input logic [PIX_W-1:0] dst);
		logic [PIX_W-1:0] res;
		res = src;
		if (src[7:0] == 8'd0) begin
			res = dst;
		end else if (src[7:0] != 8'd255 && dst[7:0] != 8'd0) begin
			res = {mix_ch(src[31:24], dst[31:24], src[7:0]),
				mix_ch(src[23:16], dst[23:16], src[7:0]),
				mix_ch(src[15:8], dst[15:8], src[7:0]), dst[7:0]};
		end
		return res;
	endfunction

	apngfc_ram #(.W(PIX_W), .D(DEPTH)) u_canvas (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	apngfc_ram #(.W(PIX_W), .D(DEPTH)) u_saved (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	assign total = POS_W'(cfg.cw) * POS_W'(cfg.ch);

	// pixel position inside the current region
	assign cx       = {2'b0, cur_rx_q} + {1'b0, col_q};
	assign cy       = {2'b0, cur_ry_q} + {1'b0, row_q};
	assign pix_in   = (32'(cx) < MAX_WIDTH) && (32'(cy) < MAX_HEIGHT);
	assign pix_addr = addr_of(cx, cy);

	assign walk_addr = addr_of({1'b0, wi_q}, {1'b0, wj_q});
	assign walk_clr  = (cur_disp_q == DISP_CLEAR)
		&& ({1'b0, wj_q} >= {2'b0, cur_ry_q})
		&& ({1'b0, wj_q} < {2'b0, cur_ry_q} + {1'b0, cur_rh_q})
		&& ({1'b0, wi_q} >= {2'b0, cur_rx_q})
		&& ({1'b0, wi_q} < {2'b0, cur_rx_q} + {1'b0, cur_rw_q});
	assign walk_done = (wi_q == cfg.cw - DIM_W'(1)) && (wj_q == cfg.ch - DIM_W'(1));

	assign rd_addr = addr_of({1'b0, rd_col_q}, {1'b0, rd_row_q});

	assign pop = (state_q == BK_IDLE) && head.valid && !out_valid_q;

	// header update, either straight away on the first frame or after the walk
	assign begin_src = (state_q == BK_IDLE) ? head.item : item_q;
	assign do_begin  = (pop && head.item.action == ACT_BEGIN && first_q)
		|| (state_q == BK_WALK_END);
	assign begin_bad = (begin_src.rw == '0) || (begin_src.rh == '0)
		|| ({1'b0, begin_src.rw} + {2'b0, begin_src.rx} > {1'b0, cfg.cw})
		|| ({1'b0, begin_src.rh} + {2'b0, begin_src.ry} > {1'b0, cfg.ch});

	// one restoring division step
	assign rem_sh  = {div_rem_q[DIM_W-1:0], div_quo_q[POS_W-1]};
	assign quo_bit = (rem_sh >= {1'b0, cfg.cw});
	assign rem_nx  = quo_bit ? (rem_sh - {1'b0, cfg.cw}) : rem_sh;
	assign quo_nx  = {div_quo_q[POS_W-2:0], quo_bit};
	assign pos_eff = (rd_pos_q >= total) ? '0 : rd_pos_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (pop) begin
					unique case (head.item.action)
						ACT_BEGIN: state_d = first_q ? BK_IDLE : BK_WALK;
						ACT_PIXEL: state_d = open_q ? BK_PIX_WR : BK_IDLE;
						ACT_READ: begin
							if (open_q) state_d = BK_IDLE;
							else if (remap_q) state_d = BK_RD_DIV;
							else state_d = BK_RD_ISSUE;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_WALK: begin
				if (walk_done) state_d = BK_WALK_END;
			end
			BK_WALK_END: state_d = BK_IDLE;
			BK_PIX_WR:   state_d = BK_IDLE;
			BK_RD_DIV: begin
				if (div_cnt_q == 5'(POS_W - 1)) state_d = BK_RD_ISSUE;
			end
			BK_RD_ISSUE: state_d = BK_RD_OUT;
			BK_RD_OUT:   state_d = BK_IDLE;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		c_we    = 1'b0;
		c_waddr = wr_addr_s1;
		c_wdata = '0;
		s_we    = 1'b0;
		s_waddr = wr_addr_s1;
		s_wdata = '0;
		s_raddr = walk_addr;
		c_raddr = pix_addr;
		unique case (state_q)
			BK_CLEAR: begin
				c_we    = 1'b1;
				s_we    = 1'b1;
				c_waddr = clr_addr_q;
				s_waddr = clr_addr_q;
			end
			BK_WALK:     c_raddr = walk_addr;
			BK_RD_ISSUE: c_raddr = rd_addr;
			BK_PIX_WR: begin
				c_we    = pix_in_s1;
				c_waddr = pix_addr_s1;
				c_wdata = cur_blend_q ? blend_over(item_q.pixel, c_rdata) : item_q.pixel;
			end
			default: c_raddr = pix_addr;
		endcase
		if (wr_vld_s1) begin
			if (cur_disp_q == DISP_RESTORE) begin
				c_we    = 1'b1;
				c_wdata = s_rdata;
			end else begin
				s_we    = 1'b1;
				s_wdata = wr_clr_s1 ? '0 : c_rdata;
				c_we    = wr_clr_s1;
				c_wdata = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= walk_addr;
		wr_clr_s1  <= walk_clr;
		if (pop) begin
			item_q      <= head.item;
			pix_addr_s1 <= pix_addr;
			pix_in_s1   <= pix_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			pixel_q     <= '0;
			last_q      <= 1'b0;
			cur_rx_q    <= '0;
			cur_ry_q    <= '0;
			cur_rw_q    <= '0;
			cur_rh_q    <= '0;
			cur_disp_q  <= DISP_NONE;
			cur_blend_q <= BLEND_SOURCE;
			first_q     <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			rd_pos_q    <= '0;
			rd_col_q    <= '0;
			rd_row_q    <= '0;
			remap_q     <= 1'b0;
			bad_q       <= 1'b0;
			open_q      <= 1'b0;
			wi_q        <= '0;
			wj_q        <= '0;
			wr_vld_s1   <= 1'b0;
			div_cnt_q   <= '0;
			div_rem_q   <= '0;
			div_quo_q   <= '0;
		end else begin
			state_q   <= state_d;
			wr_vld_s1 <= (state_q == BK_WALK);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_CLEAR: clr_addr_q <= clr_addr_q + AW'(1);
				BK_IDLE: begin
					if (pop) begin
						case (head.item.action)
							ACT_BEGIN: begin
								wi_q <= '0;
								wj_q <= '0;
							end
							ACT_PIXEL: begin
								if (!open_q) begin
									out_valid_q <= 1'b1;
									status_q    <= STAT_SEQ;
									pixel_q     <= '0;
									last_q      <= 1'b0;
								end
							end
							ACT_READ: begin
								if (open_q) begin
									out_valid_q <= 1'b1;
									status_q    <= STAT_SEQ;
									pixel_q     <= '0;
									last_q      <= 1'b0;
								end else if (remap_q) begin
									rd_pos_q  <= pos_eff;
									div_quo_q <= pos_eff;
									div_rem_q <= '0;
									div_cnt_q <= '0;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								status_q    <= STAT_SEQ;
								pixel_q     <= '0;
								last_q      <= 1'b0;
							end
						endcase
					end
				end
				BK_WALK: begin
					if (wi_q == cfg.cw - DIM_W'(1)) begin
						wi_q <= '0;
						wj_q <= wj_q + DIM_W'(1);
					end else begin
						wi_q <= wi_q + DIM_W'(1);
					end
				end
				BK_PIX_WR: begin
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					pixel_q     <= '0;
					last_q      <= 1'b0;
					if (col_q + DIM_W'(1) >= cur_rw_q) begin
						col_q <= '0;
						row_q <= row_q + DIM_W'(1);
						if (row_q + DIM_W'(1) >= cur_rh_q) begin
							open_q <= 1'b0;
							last_q <= 1'b1;
						end
					end else begin
						col_q <= col_q + DIM_W'(1);
					end
				end
				BK_RD_DIV: begin
					div_rem_q <= rem_nx;
					div_quo_q <= quo_nx;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(POS_W - 1)) begin
						rd_row_q <= quo_nx[DIM_W-1:0];
						rd_col_q <= rem_nx[DIM_W-1:0];
						remap_q  <= 1'b0;
					end
				end
				BK_RD_OUT: begin
					out_valid_q <= 1'b1;
					status_q    <= STAT_OK;
					pixel_q     <= c_rdata;
					last_q      <= (rd_pos_q + POS_W'(1) == total);
					if (rd_pos_q + POS_W'(1) == total) begin
						rd_pos_q <= '0;
						rd_col_q <= '0;
						rd_row_q <= '0;
					end else begin
						rd_pos_q <= rd_pos_q + POS_W'(1);
						if (rd_col_q == cfg.cw - DIM_W'(1)) begin
							rd_col_q <= '0;
							rd_row_q <= rd_row_q + DIM_W'(1);
						end else begin
							rd_col_q <= rd_col_q + DIM_W'(1);
						end
					end
				end
				default: ;
			endcase
			if (do_begin) begin
				cur_rx_q    <= begin_src.rx;
				cur_ry_q    <= begin_src.ry;
				cur_rw_q    <= begin_src.rw;
				cur_rh_q    <= begin_src.rh;
				cur_disp_q  <= begin_src.dispose;
				cur_blend_q <= first_q ? BLEND_SOURCE : begin_src.blend;
				first_q     <= 1'b0;
				col_q       <= '0;
				row_q       <= '0;
				rd_pos_q    <= '0;
				rd_col_q    <= '0;
				rd_row_q    <= '0;
				remap_q     <= 1'b0;
				bad_q       <= begin_bad;
				open_q      <= !begin_bad;
				out_valid_q <= 1'b1;
				status_q    <= begin_bad ? STAT_REGION : STAT_OK;
				pixel_q     <= '0;
				last_q      <= 1'b0;
			end
			if (cfg.changed) begin
				remap_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pixel_out = pixel_q;
	assign last      = last_q;

	a_pop_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_valid_q)
		else $error("item dispatched with result still pending");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !pop)
		else $error("item dispatched during clearing pass");

	a_open_good: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> !bad_q)
		else $error("region open although marked bad");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (status_q == STAT_OK))
		else $error("last flag on an error result");

endmodule

/* src/apng_frame_compositor.sv */
// top level of the apng frame compositor
// usage:
//   input channel (in_valid/in_stall) carries one item per beat: begin frame,
//   frame pixel or canvas read; every item gives exactly one result beat on
//   the output channel (out_valid/out_stall) with status, pixel_out and last
//   config channel (cfg_valid/cfg_ready) sets canvas width and height; ready
//   is always high, write only while no item is in flight
// reset:
//   both canvas memories (MAX_WIDTH*MAX_HEIGHT words) are cleared by a pass
//   after reset; items queue up during it, config writes are taken at once
// item handling (the next item is only taken once the output register frees):
//   frame pixel: read, blend and write back through the canvas ram; canvas
//   read: issue the read, then register the pixel, with a remap of the read
//   position by restoring division once after a canvas size change
//   begin frame: header at once on the first frame, otherwise after the
//   disposal and save walk over the canvas, one pixel a cycle
// stalls:
//   a stalled result holds in the output register while the front queue of
//   four items keeps taking beats; in_stall rises once that queue is full
module apng_frame_compositor import apngfc_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [DIM_W-1:0]     region_width,
	input  logic [DIM_W-1:0]     region_height,
	input  logic [COORD_W-1:0]   region_x,
	input  logic [COORD_W-1:0]   region_y,
	input  logic [1:0]           dispose_mode,
	input  logic                 blend_mode,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] cw_q, ch_q;
	logic             cfg_wr;
	cfg_t             cfg;
	item_t            item_in;
	q_head_t          head;
	logic             pop;

	// config port never back-pressures
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= DIM_RESET;
			ch_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  cw_q <= cfg_data;
				CFG_CANVAS_HEIGHT: ch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective canvas size: zero acts as one, clamp at the maximum
	assign cfg.cw = (cw_q == '0) ? DIM_W'(1) :
		((32'(cw_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cw_q);
	assign cfg.ch = (ch_q == '0) ? DIM_W'(1) :
		((32'(ch_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : ch_q);
	// any write to a real register may move the read position mapping
	assign cfg.changed = cfg_wr
		&& (cfg_index == CFG_CANVAS_WIDTH || cfg_index == CFG_CANVAS_HEIGHT);

	// pack the beat for the queue
	assign item_in.action  = action_t'(action);
	assign item_in.rw      = region_width;
	assign item_in.rh      = region_height;
	assign item_in.rx      = region_x;
	assign item_in.ry      = region_y;
	assign item_in.dispose = dispose_mode;
	assign item_in.blend   = blend_mode;
	assign item_in.pixel   = pixel_in;

	apngfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.pop      (pop),
		.head     (head)
	);

	apngfc_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.pixel_out (pixel_out),
		.last      (last)
	);

endmodule
